### rtl/cem_pkg.sv
// ----------------------------------------------------------------------------
// cem_pkg: shared types and constants
// Operation and status codes, the stored schedule record and the time stamp
// used by the cron entry match table.
// ----------------------------------------------------------------------------
package cem_pkg;

	// payload widths fixed by the interface
	localparam int IdW     = 16;
	localparam int CountW  = 5;

	// calendar limits for a valid tick
	localparam int MinuteMax = 59;
	localparam int HourMax   = 23;
	localparam int MonthMax  = 12;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_UNKNOWN_ID = 2'd2,
		STAT_RANGE      = 2'd3
	} status_t;

	// packed calendar time, also the last-fire mark of an entry
	typedef struct packed {
		logic [2:0] weekday;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
	} stamp_t;

	// schedule of one entry as held in the table
	typedef struct packed {
		logic [59:0] minute_mask;
		logic [23:0] hour_mask;
		logic [31:0] day_mask;
		logic [12:0] month_mask;
		logic [8:0]  weekday_mask;
		stamp_t      last_fire;
	} sched_t;

endpackage

### rtl/cem_entry_ram.sv
// ----------------------------------------------------------------------------
// cem_entry_ram: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cem_entry_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/cem_match.sv
// ----------------------------------------------------------------------------
// cem_match: schedule compare unit
// Tests one stored entry against the current time, cron day rules included,
// and flags a fire when the entry has not fired at this exact time yet.
// ----------------------------------------------------------------------------
module cem_match (
	input  cem_pkg::sched_t sched,
	input  cem_pkg::stamp_t now,
	output logic            fire
);

	logic minute_hit;
	logic hour_hit;
	logic month_hit;
	logic day_hit;
	logic wday_hit;
	logic day_any;
	logic wday_any;
	logic day_ok;

	// per-field mask lookups
	assign minute_hit = sched.minute_mask[now.minute];
	assign hour_hit   = sched.hour_mask[now.hour];
	assign month_hit  = sched.month_mask[now.month];
	assign day_hit    = sched.day_mask[now.day];
	assign wday_hit   = sched.weekday_mask[now.weekday];
	assign day_any    = sched.day_mask[0];
	assign wday_any   = sched.weekday_mask[8];

	// an any side defers to the other, both restricted means both must hit
	always_comb begin
		if (day_any && wday_any) begin
			day_ok = 1'b1;
		end else if (day_any) begin
			day_ok = wday_hit;
		end else if (wday_any) begin
			day_ok = day_hit;
		end else begin
			day_ok = day_hit && wday_hit;
		end
	end

	assign fire = minute_hit && hour_hit && month_hit && day_ok &&
		(sched.last_fire != now);

endmodule

### rtl/cron_entry_match_table.sv
// ----------------------------------------------------------------------------
// cron_entry_match_table: ordered table of cron entries
// Add, remove and tick operations over up to MAX_ENTRIES schedule entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry an op and its fields; in_stall is high while an
//   operation is in progress, so one operation is worked on at a time.
//   Output beats carry one result each; last_result marks the final beat
//   of an operation. An add, a rejected tick or an unused op goes straight
//   to the finish state, which loads its beat into the output register;
//   a new input beat can be taken once the sequencer is back in idle.
//   A tick walks the table one entry per cycle through the shared compare
//   unit, reading the entry memory port once per cycle while no fire beat
//   waits on the output; the summary beat ends the operation, with one fire
//   beat per matching entry before it.
//   A remove searches one entry per cycle, then moves each later entry up
//   one slot per cycle before its beat.
//   A result waits in the output register while the receiver stalls; a tick
//   walk then pauses on a firing entry until the beat is taken.
//   Reset clears the entry count and the id counter; the entry memory is
//   not cleared since only slots below the count are ever used.
// ----------------------------------------------------------------------------
module cron_entry_match_table #(
	parameter int MAX_ENTRIES = 16,
	parameter int ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [59:0] minute_mask,
	input  logic [23:0] hour_mask,
	input  logic [31:0] day_mask,
	input  logic [12:0] month_mask,
	input  logic [8:0]  weekday_mask,
	input  logic [15:0] remove_id,
	input  logic [5:0]  now_minute,
	input  logic [4:0]  now_hour,
	input  logic [4:0]  now_day,
	input  logic [3:0]  now_month,
	input  logic [2:0]  now_weekday,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        fired,
	output logic [15:0] entry_id,
	output logic [4:0]  entry_count,
	output logic        last_result
);

	localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW      = $clog2(MAX_ENTRIES + 1);
	localparam int SchedW  = $bits(cem_pkg::sched_t);
	localparam int RecW    = SchedW + ID_BITS;
	localparam int IdExtW  = (ID_BITS > cem_pkg::IdW) ? ID_BITS : cem_pkg::IdW;
	localparam int CntExtW = (CW > cem_pkg::CountW) ? CW : cem_pkg::CountW;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                  state_q, state_d;
	logic [CW-1:0]           idx_q, idx_d;
	logic [CW-1:0]           held_q, held_d;
	logic [ID_BITS-1:0]      next_id_q, next_id_d;
	cem_pkg::status_t        pend_status_q, pend_status_d;
	logic [cem_pkg::IdW-1:0] pend_id_q, pend_id_d;
	cem_pkg::stamp_t         now_q, now_d;
	logic [cem_pkg::IdW-1:0] rid_q, rid_d;

	logic                    out_valid_q;
	cem_pkg::status_t        out_status_q;
	logic                    out_fired_q;
	logic [cem_pkg::IdW-1:0] out_id_q;
	logic [4:0]              out_count_q;
	logic                    out_last_q;

	logic                    can_emit;
	logic                    out_load;
	logic                    tick_ok;
	logic                    hit;
	logic [CW:0]             idx_p1;
	logic [CW:0]             idx_p2;
	logic [IdExtW-1:0]       rd_id_ext;
	logic [IdExtW-1:0]       rid_ext;
	logic [IdExtW-1:0]       next_id_ext;
	logic [CntExtW-1:0]      held_ext;
	cem_pkg::stamp_t         in_stamp;
	cem_pkg::sched_t         new_sched;
	cem_pkg::sched_t         rd_sched;
	cem_pkg::sched_t         fire_sched;
	logic [ID_BITS-1:0]      rd_id;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [RecW-1:0]         ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [RecW-1:0]         ram_rdata;

	cem_entry_ram #(
		.ADDR_W (AW),
		.DATA_W (RecW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// stored record fields of the entry at idx_q
	assign rd_sched  = cem_pkg::sched_t'(ram_rdata[SchedW-1:0]);
	assign rd_id     = ram_rdata[RecW-1 -: ID_BITS];
	assign rd_id_ext = IdExtW'(rd_id);
	assign rid_ext   = IdExtW'(rid_q);

	cem_match u_match (
		.sched (rd_sched),
		.now   (now_q),
		.fire  (hit)
	);

	// index arithmetic and width adjust
	assign idx_p1      = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_p2      = {1'b0, idx_q} + (CW+1)'(2);
	assign next_id_ext = IdExtW'(next_id_q);
	assign held_ext    = CntExtW'(held_q);

	// tick time and range check from the input beat
	assign in_stamp = '{weekday: now_weekday, month: now_month, day: now_day,
		hour: now_hour, minute: now_minute};
	assign tick_ok = (32'(now_minute) <= cem_pkg::MinuteMax) &&
		(32'(now_hour) <= cem_pkg::HourMax) && (now_day != 5'd0) &&
		(now_month != 4'd0) && (32'(now_month) <= cem_pkg::MonthMax);

	// new entry record from an add beat, never fired
	assign new_sched = '{minute_mask: minute_mask, hour_mask: hour_mask,
		day_mask: day_mask, month_mask: month_mask, weekday_mask: weekday_mask,
		last_fire: '0};

	// fired entry gets this time as its last-fire mark
	always_comb begin
		fire_sched           = rd_sched;
		fire_sched.last_fire = now_q;
	end

	assign can_emit = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// sequencer
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		held_d        = held_q;
		next_id_d     = next_id_q;
		pend_status_d = pend_status_q;
		pend_id_d     = pend_id_q;
		now_d         = now_q;
		rid_d         = rid_q;
		ram_we        = 1'b0;
		ram_waddr     = idx_q[AW-1:0];
		ram_wdata     = {rd_id, fire_sched};
		ram_raddr     = idx_p1[AW-1:0];
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = '0;
				idx_d     = '0;
				if (in_valid) begin
					now_d = in_stamp;
					rid_d = remove_id;
					case (cem_pkg::op_t'(op))
						cem_pkg::OP_ADD: begin
							if (held_q >= CW'(MAX_ENTRIES)) begin
								pend_status_d = cem_pkg::STAT_FULL;
								pend_id_d     = '0;
							end else begin
								ram_we        = 1'b1;
								ram_waddr     = held_q[AW-1:0];
								ram_wdata     = {next_id_q, new_sched};
								held_d        = held_q + CW'(1);
								next_id_d     = next_id_q + ID_BITS'(1);
								pend_status_d = cem_pkg::STAT_OK;
								pend_id_d     = next_id_ext[cem_pkg::IdW-1:0];
							end
							state_d = ST_FINISH;
						end
						cem_pkg::OP_REMOVE: begin
							state_d = ST_SEARCH;
						end
						cem_pkg::OP_TICK: begin
							if (tick_ok) begin
								state_d = ST_SCAN;
							end else begin
								pend_status_d = cem_pkg::STAT_RANGE;
								pend_id_d     = '0;
								state_d       = ST_FINISH;
							end
						end
						default: begin
							pend_status_d = cem_pkg::STAT_OK;
							pend_id_d     = '0;
							state_d       = ST_FINISH;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// one entry per cycle, pause on a fire while output is full
				if (idx_q >= held_q) begin
					pend_status_d = cem_pkg::STAT_OK;
					pend_id_d     = '0;
					state_d       = ST_FINISH;
				end else if (hit) begin
					if (can_emit) begin
						ram_we   = 1'b1;
						out_load = 1'b1;
						idx_d    = idx_p1[CW-1:0];
					end else begin
						ram_raddr = idx_q[AW-1:0];
					end
				end else begin
					idx_d = idx_p1[CW-1:0];
				end
			end
			ST_SEARCH: begin
				if (idx_q >= held_q) begin
					pend_status_d = cem_pkg::STAT_UNKNOWN_ID;
					pend_id_d     = rid_q;
					state_d       = ST_FINISH;
				end else if (rd_id_ext == rid_ext) begin
					state_d = ST_SHIFT;
				end else begin
					idx_d = idx_p1[CW-1:0];
				end
			end
			ST_SHIFT: begin
				// read data holds the entry behind idx_q; move it up one slot
				if (idx_p1 < {1'b0, held_q}) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					idx_d     = idx_p1[CW-1:0];
					ram_raddr = idx_p2[AW-1:0];
				end else begin
					held_d        = held_q - CW'(1);
					pend_status_d = cem_pkg::STAT_OK;
					pend_id_d     = rid_q;
					state_d       = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (can_emit) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			held_q    <= '0;
			next_id_q <= '0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			held_q    <= held_d;
			next_id_q <= next_id_d;
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		pend_status_q <= pend_status_d;
		pend_id_q     <= pend_id_d;
		now_q         <= now_d;
		rid_q         <= rid_d;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: fire beats during a scan, else the final beat
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fired_q <= (state_q == ST_SCAN);
			out_last_q  <= (state_q != ST_SCAN);
			out_count_q <= held_ext[4:0];
			if (state_q == ST_SCAN) begin
				out_status_q <= cem_pkg::STAT_OK;
				out_id_q     <= rd_id_ext[cem_pkg::IdW-1:0];
			end else begin
				out_status_q <= pend_status_q;
				out_id_q     <= pend_id_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign fired       = out_fired_q;
	assign entry_id    = out_id_q;
	assign entry_count = out_count_q;
	assign last_result = out_last_q;

	// entry count never exceeds the table size
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table size");

	// walk index stays within the held entries
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SEARCH || state_q == ST_SHIFT)
		|-> idx_q <= held_q)
		else $error("walk index beyond held entries");

	// the memory is never written while searching or finishing
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != ST_SEARCH && state_q != ST_FINISH))
		else $error("entry write in a read-only state");

	// the entry count changes only on an add or at the end of a remove
	a_held_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_q) |-> ($past(state_q) == ST_IDLE ||
		$past(state_q) == ST_SHIFT))
		else $error("entry count changed outside add or remove");

	// a final beat returns the sequencer to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && can_emit) |=> (state_q == ST_IDLE && out_valid_q
		&& out_last_q))
		else $error("final beat did not end the operation");

endmodule

### tb/sv/cron_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cron_tb_pkg: beat types and table tracker for the cron table bench
// Holds a copy of the entry table, turns each accepted input beat into the
// result beats it should cause and checks the block's results in order.
// ----------------------------------------------------------------------------
package cron_tb_pkg;

	localparam int TableDepth = 16;

	// one input beat
	typedef struct packed {
		cem_pkg::op_t op;
		logic [59:0]  minute_mask;
		logic [23:0]  hour_mask;
		logic [31:0]  day_mask;
		logic [12:0]  month_mask;
		logic [8:0]   weekday_mask;
		logic [15:0]  remove_id;
		logic [5:0]   now_minute;
		logic [4:0]   now_hour;
		logic [4:0]   now_day;
		logic [3:0]   now_month;
		logic [2:0]   now_weekday;
	} cron_op_t;

	// one result beat
	typedef struct packed {
		cem_pkg::status_t status;
		logic             fired;
		logic [15:0]      entry_id;
		logic [4:0]       entry_count;
		logic             last_result;
	} cron_result_t;

	class cron_table_tracker;
		cem_pkg::sched_t sched [TableDepth];
		logic [15:0]     ids [TableDepth];
		int              held;
		logic [15:0]     next_id;
		cron_result_t    due_results [$];
		int              mismatches;

		function new();
			held = 0;
			next_id = '0;
			mismatches = 0;
		endfunction

		function void post(cem_pkg::status_t st, logic fire, logic [15:0] id, logic last);
			cron_result_t res;
			res.status = st;
			res.fired = fire;
			res.entry_id = id;
			res.entry_count = 5'(held);
			res.last_result = last;
			due_results.push_back(res);
		endfunction

		// cron day rule: an any side defers to the other, two restricted sides AND
		function bit day_matches(int e, logic [4:0] dy, logic [2:0] wd);
			bit day_any, wday_any, day_hit, wday_hit;
			day_any = sched[e].day_mask[0];
			wday_any = sched[e].weekday_mask[8];
			day_hit = sched[e].day_mask[dy];
			wday_hit = sched[e].weekday_mask[wd];
			if (day_any && wday_any)
				return 1'b1;
			if (day_any)
				return wday_hit;
			if (wday_any)
				return day_hit;
			return day_hit && wday_hit;
		endfunction

		// accepted input beat: update the table copy and queue its results
		function void note_op(cron_op_t b);
			cem_pkg::stamp_t now;
			int              slot;
			case (b.op)
				cem_pkg::OP_ADD: begin
					if (held >= TableDepth) begin
						post(cem_pkg::STAT_FULL, 1'b0, '0, 1'b1);
					end else begin
						sched[held].minute_mask = b.minute_mask;
						sched[held].hour_mask = b.hour_mask;
						sched[held].day_mask = b.day_mask;
						sched[held].month_mask = b.month_mask;
						sched[held].weekday_mask = b.weekday_mask;
						sched[held].last_fire = '0;
						ids[held] = next_id;
						held++;
						post(cem_pkg::STAT_OK, 1'b0, next_id, 1'b1);
						next_id = next_id + 16'd1;
					end
				end
				cem_pkg::OP_REMOVE: begin
					slot = -1;
					for (int i = 0; i < held; i++) begin
						if (slot < 0 && ids[i] == b.remove_id)
							slot = i;
					end
					if (slot < 0) begin
						post(cem_pkg::STAT_UNKNOWN_ID, 1'b0, b.remove_id, 1'b1);
					end else begin
						// later entries move up one slot, order kept
						for (int i = slot; i < held - 1; i++) begin
							sched[i] = sched[i + 1];
							ids[i] = ids[i + 1];
						end
						held--;
						post(cem_pkg::STAT_OK, 1'b0, b.remove_id, 1'b1);
					end
				end
				cem_pkg::OP_TICK: begin
					if (b.now_minute > cem_pkg::MinuteMax || b.now_hour > cem_pkg::HourMax ||
							b.now_day == 0 || b.now_month == 0 ||
							b.now_month > cem_pkg::MonthMax) begin
						post(cem_pkg::STAT_RANGE, 1'b0, '0, 1'b1);
					end else begin
						now.minute = b.now_minute;
						now.hour = b.now_hour;
						now.day = b.now_day;
						now.month = b.now_month;
						now.weekday = b.now_weekday;
						// walk in table order, each entry fires once per exact time
						for (int e = 0; e < held; e++) begin
							if (sched[e].minute_mask[b.now_minute] && sched[e].hour_mask[b.now_hour] &&
									sched[e].month_mask[b.now_month] &&
									day_matches(e, b.now_day, b.now_weekday) &&
									sched[e].last_fire != now) begin
								sched[e].last_fire = now;
								post(cem_pkg::STAT_OK, 1'b1, ids[e], 1'b0);
							end
						end
						post(cem_pkg::STAT_OK, 1'b0, '0, 1'b1);
					end
				end
				default: begin
					post(cem_pkg::STAT_OK, 1'b0, '0, 1'b1);
				end
			endcase
		endfunction

		function void flag(string what, logic [15:0] want, logic [15:0] got);
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		endfunction

		// result beat from the block against the oldest expected one
		function void check_result(cron_result_t got);
			cron_result_t want;
			if (due_results.size() == 0) begin
				flag("result beat with none due, entry_id", '0, got.entry_id);
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				flag("status", 16'(want.status), 16'(got.status));
			if (got.fired !== want.fired)
				flag("fired", 16'(want.fired), 16'(got.fired));
			if (got.entry_id !== want.entry_id)
				flag("entry_id", want.entry_id, got.entry_id);
			if (got.entry_count !== want.entry_count)
				flag("entry_count", 16'(want.entry_count), 16'(got.entry_count));
			if (got.last_result !== want.last_result)
				flag("last_result", 16'(want.last_result), 16'(got.last_result));
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// an id currently in the table, or any id when empty
		function logic [15:0] held_id();
			if (held == 0)
				return 16'($urandom);
			return ids[$urandom_range(0, held - 1)];
		endfunction
	endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: cron entry match table
// Directed adds, removes and ticks over the day and weekday rules and the
// range limits, then random traffic in fill, drain and tick-heavy bursts
// with random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ItemTarget    = 460;
	localparam int CycleLimit    = 1_000_000;
	localparam int HoldOffCycles = 300;
	localparam int DrainCycles   = 64;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_TICKS
	} traffic_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [59:0] minute_mask;
	logic [23:0] hour_mask;
	logic [31:0] day_mask;
	logic [12:0] month_mask;
	logic [8:0]  weekday_mask;
	logic [15:0] remove_id;
	logic [5:0]  now_minute;
	logic [4:0]  now_hour;
	logic [4:0]  now_day;
	logic [3:0]  now_month;
	logic [2:0]  now_weekday;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic        fired;
	logic [15:0] entry_id;
	logic [4:0]  entry_count;
	logic        last_result;

	cron_tb_pkg::cron_table_tracker tracker;
	int                             cycles = 0;
	int                             sent = 0;
	bit                             hold_off = 1'b0;
	cron_tb_pkg::cron_op_t          last_tick;
	bit                             have_tick = 1'b0;

	cron_entry_match_table i_dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(11, 24);
	endfunction

	// masks: mostly dense so ticks hit often, some plain, sparse and extreme
	function automatic logic [63:0] rand_mask();
		logic [63:0] a, b, c;
		int          r;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 55)
			return a | b | c;
		if (r < 80)
			return a;
		if (r < 93)
			return a & b;
		if (r < 97)
			return '1;
		return '0;
	endfunction

	function automatic cron_tb_pkg::cron_op_t make_add(logic [59:0] mi, logic [23:0] hr,
			logic [31:0] dy, logic [12:0] mo, logic [8:0] wd);
		cron_tb_pkg::cron_op_t item;
		item = '0;
		item.op = cem_pkg::OP_ADD;
		item.minute_mask = mi;
		item.hour_mask = hr;
		item.day_mask = dy;
		item.month_mask = mo;
		item.weekday_mask = wd;
		return item;
	endfunction

	function automatic cron_tb_pkg::cron_op_t make_tick(logic [5:0] mi, logic [4:0] hr,
			logic [4:0] dy, logic [3:0] mo, logic [2:0] wd);
		cron_tb_pkg::cron_op_t item;
		item = '0;
		item.op = cem_pkg::OP_TICK;
		item.now_minute = mi;
		item.now_hour = hr;
		item.now_day = dy;
		item.now_month = mo;
		item.now_weekday = wd;
		return item;
	endfunction

	function automatic cron_tb_pkg::cron_op_t make_remove(logic [15:0] id);
		cron_tb_pkg::cron_op_t item;
		item = '0;
		item.op = cem_pkg::OP_REMOVE;
		item.remove_id = id;
		return item;
	endfunction

	// random beat, op mix set by the traffic mode, unused fields random too
	function automatic cron_tb_pkg::cron_op_t rand_item(traffic_t mode);
		cron_tb_pkg::cron_op_t item;
		int                    r;
		item.minute_mask = 60'(rand_mask());
		item.hour_mask = 24'(rand_mask());
		item.day_mask = 32'(rand_mask());
		item.month_mask = 13'(rand_mask());
		item.weekday_mask = 9'(rand_mask());
		item.remove_id = 16'($urandom);
		item.now_minute = 6'($urandom);
		item.now_hour = 5'($urandom);
		item.now_day = 5'($urandom);
		item.now_month = 4'($urandom);
		item.now_weekday = 3'($urandom);
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:  item.op = r < 70 ? cem_pkg::OP_ADD : r < 88 ? cem_pkg::OP_TICK :
				r < 96 ? cem_pkg::OP_REMOVE : cem_pkg::OP_NOP;
			MODE_DRAIN: item.op = r < 60 ? cem_pkg::OP_REMOVE : r < 85 ? cem_pkg::OP_TICK :
				r < 95 ? cem_pkg::OP_ADD : cem_pkg::OP_NOP;
			default:    item.op = r < 70 ? cem_pkg::OP_TICK : r < 80 ? cem_pkg::OP_ADD :
				r < 95 ? cem_pkg::OP_REMOVE : cem_pkg::OP_NOP;
		endcase
		if (item.op == cem_pkg::OP_REMOVE && $urandom_range(0, 99) < 85)
			item.remove_id = tracker.held_id();
		if (item.op == cem_pkg::OP_TICK) begin
			r = $urandom_range(0, 99);
			if (r < 20 && have_tick) begin
				// same time again, nothing may fire twice
				item.now_minute = last_tick.now_minute;
				item.now_hour = last_tick.now_hour;
				item.now_day = last_tick.now_day;
				item.now_month = last_tick.now_month;
				item.now_weekday = last_tick.now_weekday;
			end else if (r < 87) begin
				item.now_minute = 6'($urandom_range(0, cem_pkg::MinuteMax));
				item.now_hour = 5'($urandom_range(0, cem_pkg::HourMax));
				item.now_day = 5'($urandom_range(1, 31));
				item.now_month = 4'($urandom_range(1, cem_pkg::MonthMax));
				item.now_weekday = 3'($urandom_range(0, 7));
				last_tick = item;
				have_tick = 1'b1;
			end
		end
		return item;
	endfunction

	// drive one beat and wait for it to be taken
	task automatic send_op(input cron_tb_pkg::cron_op_t item);
		op <= item.op;
		minute_mask <= item.minute_mask;
		hour_mask <= item.hour_mask;
		day_mask <= item.day_mask;
		month_mask <= item.month_mask;
		weekday_mask <= item.weekday_mask;
		remove_id <= item.remove_id;
		now_minute <= item.now_minute;
		now_hour <= item.now_hour;
		now_day <= item.now_day;
		now_month <= item.now_month;
		now_weekday <= item.now_weekday;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_op(item);
		sent++;
	endtask

	task automatic send_paced(input cron_tb_pkg::cron_op_t item, input bit gaps);
		int n;
		send_op(item);
		n = gaps && !hold_off ? pick_gap() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		cron_tb_pkg::cron_op_t item;
		traffic_t              mode;
		int                    burst;
		bit                    gaps;
		bit                    pressed;
		tracker = new();
		pressed = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= cem_pkg::OP_NOP;
		minute_mask <= '0;
		hour_mask <= '0;
		day_mask <= '0;
		month_mask <= '0;
		weekday_mask <= '0;
		remove_id <= '0;
		now_minute <= '0;
		now_hour <= '0;
		now_day <= '0;
		now_month <= '0;
		now_weekday <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: tick gives only the summary, remove misses
		send_paced(make_tick(6'd0, 5'd0, 5'd1, 4'd1, 3'd0), 1'b1);
		send_paced(make_remove(16'hFFFF), 1'b1);
		// entries: everything, both day sides restricted, day any with weekday
		// seven, weekday any with day 31, nothing at all
		send_paced(make_add('1, '1, '1, '1, '1), 1'b1);
		send_paced(make_add(60'd1 << 30, 24'd1 << 12, 32'd1 << 15, 13'd1 << 6, 9'd1 << 3), 1'b1);
		send_paced(make_add(60'd1 << 59, 24'd1 << 23, 32'd1, 13'd1 << 12, 9'h080), 1'b1);
		send_paced(make_add(60'd1, 24'd1, 32'd1 << 31, 13'd1 << 1, 9'h100), 1'b1);
		send_paced(make_add('0, '0, '0, '0, '0), 1'b1);
		// fire, repeat the exact time, then weekday mismatch on a restricted pair
		send_paced(make_tick(6'd30, 5'd12, 5'd15, 4'd6, 3'd3), 1'b1);
		send_paced(make_tick(6'd30, 5'd12, 5'd15, 4'd6, 3'd3), 1'b1);
		send_paced(make_tick(6'd30, 5'd12, 5'd15, 4'd6, 3'd2), 1'b1);
		// weekday seven against weekday zero
		send_paced(make_tick(6'd59, 5'd23, 5'd20, 4'd12, 3'd7), 1'b1);
		send_paced(make_tick(6'd59, 5'd23, 5'd20, 4'd12, 3'd0), 1'b1);
		send_paced(make_tick(6'd0, 5'd0, 5'd31, 4'd1, 3'd5), 1'b1);
		// out of range times
		send_paced(make_tick(6'd60, 5'd0, 5'd1, 4'd1, 3'd0), 1'b1);
		send_paced(make_tick(6'd0, 5'd24, 5'd1, 4'd1, 3'd0), 1'b1);
		send_paced(make_tick(6'd0, 5'd0, 5'd0, 4'd1, 3'd0), 1'b1);
		send_paced(make_tick(6'd0, 5'd0, 5'd1, 4'd0, 3'd0), 1'b1);
		send_paced(make_tick(6'd0, 5'd0, 5'd1, 4'd13, 3'd0), 1'b1);
		send_paced(make_tick(6'd63, 5'd31, 5'd31, 4'd15, 3'd7), 1'b1);
		// unused op with every field high
		item = '1;
		item.op = cem_pkg::OP_NOP;
		send_paced(item, 1'b1);
		// remove from the middle, again, then the head
		send_paced(make_remove(16'd1), 1'b1);
		send_paced(make_tick(6'd30, 5'd12, 5'd15, 4'd6, 3'd3), 1'b1);
		send_paced(make_remove(16'd1), 1'b1);
		send_paced(make_remove(16'd0), 1'b1);

		// random bursts, one long output hold-off halfway through
		while (sent < ItemTarget) begin
			mode = traffic_t'($urandom_range(0, 2));
			burst = $urandom_range(8, 30);
			gaps = $urandom_range(0, 3) != 0;
			for (int k = 0; k < burst && sent < ItemTarget; k++) begin
				if (!pressed && sent >= ItemTarget / 2) begin
					pressed = 1'b1;
					hold_off = 1'b1;
				end
				send_paced(rand_item(mode), gaps);
			end
		end
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: check each beat taken, then pick the next stall
	initial begin
		cron_tb_pkg::cron_result_t res;
		int                        stall_left;
		int                        hold_left;
		int                        burst_left;
		bit                        calm;
		int                        r;
		stall_left = 0;
		hold_left = 0;
		burst_left = 0;
		calm = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				res.status = cem_pkg::status_t'(status);
				res.fired = fired;
				res.entry_id = entry_id;
				res.entry_count = entry_count;
				res.last_result = last_result;
				tracker.check_result(res);
			end
			if (hold_off) begin
				// long hold-off so the block backs up into its input
				if (hold_left == 0)
					hold_left = HoldOffCycles;
				hold_left--;
				if (hold_left == 0)
					hold_off = 1'b0;
				out_stall <= 1'b1;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(20, 120);
					calm = $urandom_range(0, 3) == 0;
				end
				burst_left--;
				if (stall_left > 0) begin
					stall_left--;
				end else if (!calm) begin
					r = $urandom_range(0, 99);
					stall_left = r < 60 ? 0 : r < 88 ? $urandom_range(1, 3) :
						r < 97 ? $urandom_range(4, 12) : $urandom_range(13, 32);
				end
				out_stall <= stall_left > 0;
			end
		end
	end

endmodule
